FILE: rtl/transfer_init_message_parser_top_assert.svh
// Assertion macros for the transfer-init message parser checker.
`ifndef TRANSFER_INIT_MESSAGE_PARSER_TOP_ASSERT_SVH
`define TRANSFER_INIT_MESSAGE_PARSER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TIMP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("transfer init parser check failed");

// Check a property on every clock edge, reset included.
`define TIMP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("transfer init parser check failed");

`endif

FILE: rtl/timp_pkg.sv
// Types and constants shared by the transfer-init message parser files.
`timescale 1ns / 1ps
package timp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [3:0]  versions;
    logic [2:0]  drive_flags;
    logic [15:0] max_block_size;
    logic [63:0] start_offset;
    logic [63:0] max_length;
    logic [15:0] designator_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    PH_TC,
    PH_RC,
    PH_BS,
    PH_OFF,
    PH_LEN,
    PH_DL,
    PH_DES,
    PH_META
  } phase_t;

  localparam logic [1:0] KIND_HEADER     = 2'd0;
  localparam logic [1:0] KIND_DESIGNATOR = 2'd1;
  localparam logic [1:0] KIND_METADATA   = 2'd2;
  localparam logic [1:0] KIND_END        = 2'd3;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_TRUNCATED  = 2'd1;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

  // Range flag bit positions.
  localparam int unsigned RF_LEN_BIT  = 0;
  localparam int unsigned RF_OFF_BIT  = 1;
  localparam int unsigned RF_WIDE_BIT = 2;

  // Result queue: one byte can yield two results.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Results produced by one accepted byte, first in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

FILE: rtl/timp_parser.sv
// Header phase machine, field accumulators and result formatting.
`timescale 1ns / 1ps
module timp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  timp_pkg::in_item_t item,
  output timp_pkg::push_t    push
);
  import timp_pkg::*;

  phase_t      phase, phase_next, phase_mid;
  logic [2:0]  field_byte_count, field_byte_count_next;
  logic [2:0]  range_flags, range_flags_next;
  logic [6:0]  version_and_drive, version_and_drive_next;
  logic [15:0] block_size_acc, block_size_acc_next;
  logic [63:0] offset_acc, offset_acc_next;
  logic [63:0] length_acc, length_acc_next;
  logic [15:0] designator_remaining, designator_remaining_next;

  logic [7:0]  b;
  logic [15:0] b_lane16;
  logic [63:0] b_lane64;
  logic        range_done;
  logic        header_done;
  logic        has_main;
  result_t     main_rec, end_rec;

  assign b        = item.in_byte;
  assign b_lane16 = field_byte_count[0] ? {b, 8'h00} : {8'h00, b};
  assign b_lane64 = 64'(b) << {field_byte_count, 3'b000};
  // Offset and length are 8 bytes when wide, else 4.
  assign range_done = range_flags[RF_WIDE_BIT] ? (field_byte_count == 3'd7)
                                               : (field_byte_count >= 3'd3);
  assign header_done = (phase == PH_DL) && (field_byte_count != 3'd0);

  // Next state.
  always_comb begin
    phase_mid                 = phase;
    field_byte_count_next     = field_byte_count;
    range_flags_next          = range_flags;
    version_and_drive_next    = version_and_drive;
    block_size_acc_next       = block_size_acc;
    offset_acc_next           = offset_acc;
    length_acc_next           = length_acc;
    designator_remaining_next = designator_remaining;
    unique case (phase)
      PH_RC: begin
        range_flags_next      = {b[4], b[1], b[0]};
        field_byte_count_next = 3'd0;
        phase_mid             = PH_BS;
      end
      PH_BS: begin
        block_size_acc_next = block_size_acc | b_lane16;
        if (field_byte_count != 3'd0) begin
          field_byte_count_next = 3'd0;
          if (range_flags[RF_OFF_BIT]) phase_mid = PH_OFF;
          else if (range_flags[RF_LEN_BIT]) phase_mid = PH_LEN;
          else phase_mid = PH_DL;
        end else begin
          field_byte_count_next = field_byte_count + 3'd1;
        end
      end
      PH_OFF: begin
        offset_acc_next = offset_acc | b_lane64;
        if (range_done) begin
          field_byte_count_next = 3'd0;
          phase_mid = range_flags[RF_LEN_BIT] ? PH_LEN : PH_DL;
        end else begin
          field_byte_count_next = field_byte_count + 3'd1;
        end
      end
      PH_LEN: begin
        length_acc_next = length_acc | b_lane64;
        if (range_done) begin
          field_byte_count_next = 3'd0;
          phase_mid = PH_DL;
        end else begin
          field_byte_count_next = field_byte_count + 3'd1;
        end
      end
      PH_DL: begin
        designator_remaining_next = designator_remaining | b_lane16;
        if (header_done) begin
          field_byte_count_next = 3'd0;
          phase_mid = (designator_remaining_next != 16'd0) ? PH_DES : PH_META;
        end else begin
          field_byte_count_next = field_byte_count + 3'd1;
        end
      end
      PH_DES: begin
        designator_remaining_next = designator_remaining - 16'd1;
        if (designator_remaining_next == 16'd0) phase_mid = PH_META;
      end
      PH_META: begin
      end
      PH_TC: begin
        // Start of a new message: clear every accumulator.
        version_and_drive_next    = b[6:0];
        range_flags_next          = 3'd0;
        block_size_acc_next       = 16'd0;
        offset_acc_next           = 64'd0;
        length_acc_next           = 64'd0;
        designator_remaining_next = 16'd0;
        field_byte_count_next     = 3'd0;
        phase_mid                 = PH_RC;
      end
      default: phase_mid = PH_TC;
    endcase
    phase_next = phase_mid;
    if (item.end_of_message) begin
      phase_next            = PH_TC;
      field_byte_count_next = 3'd0;
    end
  end

  // Result records.
  always_comb begin
    main_rec = '0;
    end_rec  = '0;
    has_main = 1'b0;
    if (header_done) begin
      has_main                   = 1'b1;
      main_rec.kind              = KIND_HEADER;
      main_rec.versions          = version_and_drive[3:0];
      main_rec.drive_flags       = version_and_drive[6:4];
      main_rec.max_block_size    = block_size_acc;
      main_rec.start_offset      = offset_acc;
      main_rec.max_length        = length_acc;
      main_rec.designator_length = designator_remaining_next;
    end else if (phase == PH_DES) begin
      has_main              = 1'b1;
      main_rec.kind         = KIND_DESIGNATOR;
      main_rec.payload_byte = b;
    end else if (phase == PH_META) begin
      has_main              = 1'b1;
      main_rec.kind         = KIND_METADATA;
      main_rec.payload_byte = b;
    end
    end_rec.kind = KIND_END;
    end_rec.last = 1'b1;
    if (phase_mid == PH_DES) end_rec.status = STATUS_INCOMPLETE;
    else if (phase_mid == PH_META) end_rec.status = STATUS_OK;
    else end_rec.status = STATUS_TRUNCATED;

    push.count  = accept ? ({1'b0, has_main} + {1'b0, item.end_of_message}) : 2'd0;
    push.first  = has_main ? main_rec : end_rec;
    push.second = end_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_TC;
      field_byte_count     <= 3'd0;
      range_flags          <= 3'd0;
      version_and_drive    <= 7'd0;
      block_size_acc       <= 16'd0;
      offset_acc           <= 64'd0;
      length_acc           <= 64'd0;
      designator_remaining <= 16'd0;
    end else if (accept) begin
      phase                <= phase_next;
      field_byte_count     <= field_byte_count_next;
      range_flags          <= range_flags_next;
      version_and_drive    <= version_and_drive_next;
      block_size_acc       <= block_size_acc_next;
      offset_acc           <= offset_acc_next;
      length_acc           <= length_acc_next;
      designator_remaining <= designator_remaining_next;
    end
  end

endmodule

FILE: rtl/timp_queue.sv
// Small result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps
module timp_queue (
  input  logic              clk,
  input  logic              rst,
  input  timp_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output timp_pkg::result_t out_data
);
  import timp_pkg::*;

  result_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   head, tail, tail_plus;
  logic [QCNT_W-1:0]   count, count_next;
  logic                pop;

  assign tail_plus = tail + QPTR_W'(1);
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[head];
  // Leave room for the two results one byte can bring.
  assign room      = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign count_next = count + QCNT_W'(push.count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[tail] <= push.first;
    if (push.count == 2'd2) mem[tail_plus] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) head <= head + QPTR_W'(1);
      tail  <= tail + QPTR_W'(push.count);
      count <= count_next;
    end
  end

endmodule

FILE: rtl/transfer_init_message_parser_top.sv
// Top level of the transfer-init message parser.
// A byte's results are registered into the result queue and offered on out_valid in order.
// Throughput: one byte per cycle; in_ready holds while two queue slots are free.
// A byte that ends the message and also yields a record brings two results,
// drained one per cycle while out_ready is high.
// Reset (rst, synchronous) empties the result queue and rearms for a control byte.
`timescale 1ns / 1ps
module transfer_init_message_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  timp_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output timp_pkg::result_t  out_data
);
  import timp_pkg::*;

  push_t push;
  logic  room;
  logic  in_xfer;

  // Take a byte whenever the queue can absorb the worst case of two results,
  // independent of whether the consumer is currently taking a result.
  assign in_ready = room;
  assign in_xfer  = in_valid && in_ready;

  // Advance the phase machine and format the results of this byte.
  timp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (in_xfer),
    .item   (in_data),
    .push   (push)
  );

  // Hold results until the consumer takes them, in order.
  timp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/timp_checker.sv
// Port-level checker for the transfer-init message parser, with its bind.
`timescale 1ns / 1ps
`include "transfer_init_message_parser_top_assert.svh"
module timp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input timp_pkg::in_item_t in_data,
  input logic               out_valid,
  input logic               out_ready,
  input timp_pkg::result_t  out_data
);
  import timp_pkg::*;

  `TIMP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `TIMP_ASSERT(a_end_shows, in_valid && in_ready && in_data.end_of_message |=> out_valid)
  `TIMP_ASSERT(a_last_is_end, out_valid && out_data.last |-> out_data.kind == KIND_END)
  `TIMP_ASSERT(a_no_hdr_fields, out_valid && out_data.kind != KIND_HEADER |-> out_data.start_offset == 64'd0 && out_data.max_length == 64'd0)
  `TIMP_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

endmodule

bind transfer_init_message_parser_top timp_checker u_checker (.*);

FILE: dv/tb_transfer_init_message_parser_top.sv
// Self-checking testbench for the transfer-init message parser top level.
`timescale 1ns / 1ps
module tb_transfer_init_message_parser_top;
  import timp_pkg::*;

  // Directed stimulus row: one message byte, plus an optional end status that
  // can be read straight off the message layout.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       eom;
    logic       pinned;
    logic [1:0] end_status;
  } stim_row_t;

  // Clock, reset and DUT-facing signals; every input is known from time zero.
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  result_t    out_data;

  // Parser shadow state, kept in step with every accepted byte.
  phase_t      parse_phase     = PH_TC;
  logic [2:0]  field_idx       = '0;
  logic [2:0]  range_bits      = '0;
  logic [6:0]  ctrl_bits       = '0;
  logic [15:0] block_size      = '0;
  logic [63:0] offset_val      = '0;
  logic [63:0] length_val      = '0;
  logic [15:0] designator_left = '0;

  // Results the parser still owes, oldest first.
  result_t pending_results[$];

  // Handshake shaping: idle percentages per side and a one-shot long hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          long_hold_req = 1'b0;

  // Run bookkeeping for the summary.
  int unsigned n_errors     = 0;
  int unsigned n_pin_errors = 0;
  int unsigned n_bytes      = 0;
  int unsigned n_messages   = 0;
  int unsigned kind_seen[4];
  result_t     got_result;
  result_t     want_result;

  // Directed part: after-reset truncation, a header that completes on the
  // final byte with only ignored control bits set, and an all-ones narrow
  // header whose designator is cut short.
  stim_row_t directed_rows[22] = '{
    // Control byte alone, then end: header truncated.
    '{8'h00, 1'b1, 1'b1, STATUS_TRUNCATED},
    // Only bit 7 in transfer control, only spare bits in range control,
    // zero block size, zero designator length, end on the last header byte.
    '{8'h80, 1'b0, 1'b0, STATUS_OK},
    '{8'hEC, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b1, 1'b1, STATUS_OK},
    // All flags, narrow offset and length, every field at its maximum,
    // designator length 0xFFFF and a single designator byte before end.
    '{8'h7F, 1'b0, 1'b0, STATUS_OK},
    '{8'h03, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b1, 1'b1, STATUS_INCOMPLETE}
  };

  transfer_init_message_parser_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the shadow parser by one byte and queue the results it yields.
  // Hand back the last result of this byte so pinned rows can be cross-checked.
  task automatic parse_message_byte(input logic [7:0] b, input logic eom,
                                    output result_t tail);
    result_t rec;
    int      field_len;
    field_len = range_bits[RF_WIDE_BIT] ? 8 : 4;
    tail = '0;
    rec  = '0;
    case (parse_phase)
      PH_RC: begin
        // Keep only length, offset and wide; drop the spare bits.
        range_bits  = {b[4], b[1], b[0]};
        field_idx   = '0;
        parse_phase = PH_BS;
      end
      PH_BS: begin
        block_size = block_size | (16'(b) << (8 * field_idx[0]));
        if (field_idx[0]) begin
          field_idx = '0;
          if (range_bits[RF_OFF_BIT]) parse_phase = PH_OFF;
          else if (range_bits[RF_LEN_BIT]) parse_phase = PH_LEN;
          else parse_phase = PH_DL;
        end else begin
          field_idx = field_idx + 3'd1;
        end
      end
      PH_OFF: begin
        offset_val = offset_val | (64'(b) << (8 * field_idx));
        if (int'(field_idx) + 1 >= field_len) begin
          field_idx   = '0;
          parse_phase = range_bits[RF_LEN_BIT] ? PH_LEN : PH_DL;
        end else begin
          field_idx = field_idx + 3'd1;
        end
      end
      PH_LEN: begin
        length_val = length_val | (64'(b) << (8 * field_idx));
        if (int'(field_idx) + 1 >= field_len) begin
          field_idx   = '0;
          parse_phase = PH_DL;
        end else begin
          field_idx = field_idx + 3'd1;
        end
      end
      PH_DL: begin
        designator_left = designator_left | (16'(b) << (8 * field_idx[0]));
        if (field_idx[0]) begin
          // Header complete: emit the record, then route by designator length.
          field_idx             = '0;
          rec.kind              = KIND_HEADER;
          rec.versions          = ctrl_bits[3:0];
          rec.drive_flags       = ctrl_bits[6:4];
          rec.max_block_size    = block_size;
          rec.start_offset      = offset_val;
          rec.max_length        = length_val;
          rec.designator_length = designator_left;
          pending_results.push_back(rec);
          tail        = rec;
          parse_phase = (designator_left != 16'd0) ? PH_DES : PH_META;
        end else begin
          field_idx = field_idx + 3'd1;
        end
      end
      PH_DES: begin
        rec.kind         = KIND_DESIGNATOR;
        rec.payload_byte = b;
        pending_results.push_back(rec);
        tail            = rec;
        designator_left = designator_left - 16'd1;
        if (designator_left == 16'd0) parse_phase = PH_META;
      end
      PH_META: begin
        rec.kind         = KIND_METADATA;
        rec.payload_byte = b;
        pending_results.push_back(rec);
        tail = rec;
      end
      default: begin
        // Start of a new message: drop bit 7 and clear every accumulator.
        ctrl_bits       = b[6:0];
        range_bits      = '0;
        block_size      = '0;
        offset_val      = '0;
        length_val      = '0;
        designator_left = '0;
        field_idx       = '0;
        parse_phase     = PH_RC;
      end
    endcase

    if (eom) begin
      rec      = '0;
      rec.kind = KIND_END;
      rec.last = 1'b1;
      if (parse_phase == PH_DES) rec.status = STATUS_INCOMPLETE;
      else if (parse_phase == PH_META) rec.status = STATUS_OK;
      else rec.status = STATUS_TRUNCATED;
      pending_results.push_back(rec);
      tail        = rec;
      parse_phase = PH_TC;
      field_idx   = '0;
    end
  endtask

  // Offer one byte from a falling edge, idling first at random, and hold it
  // until the transfer; return at the following falling edge.
  task automatic send_byte(input logic [7:0] b, input logic eom,
                           input logic pinned, input logic [1:0] end_status);
    result_t tail;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, eom};
    do @(posedge clk); while (!in_ready);
    parse_message_byte(b, eom, tail);
    n_bytes++;
    if (eom) n_messages++;
    if (pinned && (tail.kind !== KIND_END || tail.status !== end_status)) begin
      $display("%0t: end status mismatch, expected kind %0d status %0d, actual kind %0d status %0d",
               $time, KIND_END, end_status, tail.kind, tail.status);
      n_pin_errors++;
    end
    @(negedge clk);
  endtask

  // Build one message and send it, end flag on its final byte. Most are
  // well-formed with random content; the rest are cut off in the header,
  // stop short of a long designator, or are plain noise.
  task automatic send_random_message();
    logic [7:0] msg[$];
    logic [7:0] rc;
    int         field_len;
    int         shape;
    int         dlen;
    int         head_len;
    int         cut;
    shape = $urandom_range(99);
    if (shape < 5) begin
      repeat ($urandom_range(12, 1)) msg.push_back(8'($urandom_range(255)));
    end else begin
      rc = 8'($urandom_range(255));
      msg.push_back(8'($urandom_range(255)));
      msg.push_back(rc);
      field_len = rc[4] ? 8 : 4;
      repeat (2) msg.push_back(8'($urandom_range(255)));
      if (rc[1]) repeat (field_len) msg.push_back(8'($urandom_range(255)));
      if (rc[0]) repeat (field_len) msg.push_back(8'($urandom_range(255)));
      if (shape < 15) dlen = $urandom_range(65535);
      else if (shape < 22) dlen = $urandom_range(40);
      else dlen = $urandom_range(6);
      msg.push_back(8'(dlen));
      msg.push_back(8'(dlen >> 8));
      head_len = msg.size();
      if (shape < 15) begin
        // Any designator length, but only a few of its bytes.
        repeat ($urandom_range(3)) msg.push_back(8'($urandom_range(255)));
      end else begin
        repeat (dlen) msg.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(4)) msg.push_back(8'($urandom_range(255)));
      end
      if (shape >= 85) begin
        // Truncate somewhere inside the header.
        cut = $urandom_range(head_len - 1, 1);
        while (msg.size() > cut) void'(msg.pop_back());
      end
    end
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1, 1'b0, STATUS_OK);
  endtask

  // Report one field that differs from its expectation.
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Receiver: drop ready at random from each falling edge, and on request
  // hold it low for a long stretch so the result queue fills and in_ready drops.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Scoreboard: compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_result = out_data;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got_result);
        n_errors++;
      end else begin
        want_result = pending_results.pop_front();
        kind_seen[got_result.kind]++;
        check_field("kind", 64'(want_result.kind), 64'(got_result.kind));
        check_field("status", 64'(want_result.status), 64'(got_result.status));
        check_field("versions", 64'(want_result.versions), 64'(got_result.versions));
        check_field("drive_flags", 64'(want_result.drive_flags),
                    64'(got_result.drive_flags));
        check_field("max_block_size", 64'(want_result.max_block_size),
                    64'(got_result.max_block_size));
        check_field("start_offset", want_result.start_offset, got_result.start_offset);
        check_field("max_length", want_result.max_length, got_result.max_length);
        check_field("designator_length", 64'(want_result.designator_length),
                    64'(got_result.designator_length));
        check_field("payload_byte", 64'(want_result.payload_byte),
                    64'(got_result.payload_byte));
        check_field("last", 64'(want_result.last), 64'(got_result.last));
      end
    end
  end

  // Main sequence: reset, then three handshake regimes.
  initial begin : stimulus
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sender mostly busy, receiver mostly stalled; directed rows go first.
    send_idle_pct = 19;
    recv_idle_pct = 70;
    foreach (directed_rows[i])
      send_byte(directed_rows[i].data_byte, directed_rows[i].eom,
                directed_rows[i].pinned, directed_rows[i].end_status);
    while (n_bytes < 180) send_random_message();

    // Swap: sender gappy, receiver mostly ready.
    send_idle_pct = 70;
    recv_idle_pct = 19;
    while (n_bytes < 340) send_random_message();

    // Full rate both ways, with one long output hold-off to force backpressure.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    while (n_bytes < 520) send_random_message();
    in_valid <= 1'b0;

    // Drain, then keep watching for any stray result.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d messages across three handshake regimes with a long output hold-off.",
             n_bytes, n_messages);
    $display("Checked %0d header records, %0d designator bytes, %0d metadata bytes, %0d end statuses.",
             kind_seen[KIND_HEADER], kind_seen[KIND_DESIGNATOR], kind_seen[KIND_METADATA],
             kind_seen[KIND_END]);
    if (n_errors == 0 && n_pin_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d results still expected", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: transfer_init_message_parser_top.f
+incdir+rtl
rtl/timp_pkg.sv
rtl/timp_parser.sv
rtl/timp_queue.sv
rtl/transfer_init_message_parser_top.sv
rtl/timp_checker.sv
dv/tb_transfer_init_message_parser_top.sv
